// ===== hdl/lr_pkg.sv =====
// Package for the line rasteriser: coordinate width default and item kind codes.
// Depends on nothing; imported by every module of the block.
`default_nettype none

package lr_pkg;

	localparam int LR_COORD_BITS = 16;
	localparam int LR_COLOR_BITS = 24;

	localparam logic LR_OP_START = 1'b0;
	localparam logic LR_OP_STEP  = 1'b1;

endpackage

`default_nettype wire

// ===== hdl/line_rasterizer_top.sv =====
// Top level of the line rasteriser: input register, line state and pixel output register.
// Depends on lr_pkg, lr_setup and lr_step.
//
// Channel  Dir  Handshake           Payload
// s_axis   in   tvalid / tready     tuser: opcode; tdata: start/end points, colour
// m_axis   out  tvalid / tready     tdata: pixel x, y, colour; tlast: end point
//
// Each item is held in the input register, and a step item's pixel in the output register;
// a new item is taken every cycle while the output side keeps up.
// A step item's work is a single add and compare on the error term.
// Reset clears the line state and leaves the block idle with no pixel pending.
// A stalled output holds both registers; the input register frees as soon as it moves on.
`default_nettype none

module line_rasterizer_top
	import lr_pkg::*;
#(
	parameter int COORD_BITS = LR_COORD_BITS
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        s_axis_tvalid,
	output logic                        s_axis_tready,
	// opcode
	input  logic                        s_axis_tuser,
	// start_x, start_y, end_x, end_y, color, zero padding
	input  logic [((4*COORD_BITS+LR_COLOR_BITS+7)/8)*8-1:0] s_axis_tdata,
	output logic                        m_axis_tvalid,
	input  logic                        m_axis_tready,
	// pixel_x, pixel_y, pixel_color, zero padding
	output logic [((2*COORD_BITS+LR_COLOR_BITS+7)/8)*8-1:0] m_axis_tdata,
	output logic                        m_axis_tlast
);

	localparam int C     = COORD_BITS;
	localparam int E     = COORD_BITS + 3;
	localparam int OUT_W = ((2*COORD_BITS+LR_COLOR_BITS+7)/8)*8;

	logic                     valid_s1;
	logic                     op_s1;
	logic signed [C-1:0]      sx_s1, sy_s1, ex_s1, ey_s1;
	logic [LR_COLOR_BITS-1:0] color_s1;

	logic signed [C-1:0]      cur_x_q, cur_y_q, target_x_q, target_y_q;
	logic signed [E-1:0]      error_q, straight_q, diagonal_q;
	logic                     x_major_q;
	logic [LR_COLOR_BITS-1:0] line_color_q;
	logic                     active_q;

	logic                     valid_s2;
	logic signed [C-1:0]      px_s2, py_s2;
	logic [LR_COLOR_BITS-1:0] pcolor_s2;
	logic                     last_s2;

	logic                     advance;
	logic                     emit;

	logic signed [C-1:0]      su_fx, su_fy, su_sx, su_sy;
	logic signed [E-1:0]      su_err, su_str, su_diag;
	logic                     su_xmaj;

	logic signed [C-1:0]      st_x, st_y;
	logic signed [E-1:0]      st_err;
	logic                     st_last;

	assign advance       = !valid_s2 || m_axis_tready;
	assign s_axis_tready = !valid_s1 || advance;
	assign emit          = valid_s1 && (op_s1 == LR_OP_STEP) && active_q;

	lr_setup #(.COORD_BITS(C)) u_setup (
		.start_x      (sx_s1),
		.start_y      (sy_s1),
		.end_x        (ex_s1),
		.end_y        (ey_s1),
		.first_x      (su_fx),
		.first_y      (su_fy),
		.second_x     (su_sx),
		.second_y     (su_sy),
		.error_init   (su_err),
		.straight_inc (su_str),
		.diagonal_inc (su_diag),
		.x_major      (su_xmaj)
	);

	lr_step #(.COORD_BITS(C)) u_step (
		.cur_x        (cur_x_q),
		.cur_y        (cur_y_q),
		.target_x     (target_x_q),
		.target_y     (target_y_q),
		.error_term   (error_q),
		.straight_inc (straight_q),
		.diagonal_inc (diagonal_q),
		.x_major      (x_major_q),
		.next_x       (st_x),
		.next_y       (st_y),
		.next_error   (st_err),
		.is_last      (st_last)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			op_s1    <= s_axis_tuser;
			sx_s1    <= s_axis_tdata[C-1:0];
			sy_s1    <= s_axis_tdata[2*C-1:C];
			ex_s1    <= s_axis_tdata[3*C-1:2*C];
			ey_s1    <= s_axis_tdata[4*C-1:3*C];
			color_s1 <= s_axis_tdata[4*C+LR_COLOR_BITS-1:4*C];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_x_q      <= '0;
			cur_y_q      <= '0;
			target_x_q   <= '0;
			target_y_q   <= '0;
			error_q      <= '0;
			straight_q   <= '0;
			diagonal_q   <= '0;
			x_major_q    <= 1'b0;
			line_color_q <= '0;
			active_q     <= 1'b0;
		end else if (valid_s1 && advance) begin
			if (op_s1 == LR_OP_START) begin
				cur_x_q      <= su_fx;
				cur_y_q      <= su_fy;
				target_x_q   <= su_sx;
				target_y_q   <= su_sy;
				error_q      <= su_err;
				straight_q   <= su_str;
				diagonal_q   <= su_diag;
				x_major_q    <= su_xmaj;
				line_color_q <= color_s1;
				active_q     <= 1'b1;
			end else if (active_q) begin
				cur_x_q  <= st_x;
				cur_y_q  <= st_y;
				error_q  <= st_err;
				active_q <= !st_last;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= emit;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && emit) begin
			px_s2     <= st_x;
			py_s2     <= st_y;
			pcolor_s2 <= line_color_q;
			last_s2   <= st_last;
		end
	end

	assign m_axis_tvalid = valid_s2;
	assign m_axis_tdata  = OUT_W'({pcolor_s2, py_s2, px_s2});
	assign m_axis_tlast  = last_s2;

endmodule

`default_nettype wire

// ===== hdl/lr_setup.sv =====
// Line setup: endpoint ordering, deltas, initial error term and increments.
// Depends on lr_pkg.
`default_nettype none

module lr_setup
	import lr_pkg::*;
#(
	parameter int COORD_BITS = LR_COORD_BITS
) (
	input  logic signed [COORD_BITS-1:0] start_x,
	input  logic signed [COORD_BITS-1:0] start_y,
	input  logic signed [COORD_BITS-1:0] end_x,
	input  logic signed [COORD_BITS-1:0] end_y,
	output logic signed [COORD_BITS-1:0] first_x,
	output logic signed [COORD_BITS-1:0] first_y,
	output logic signed [COORD_BITS-1:0] second_x,
	output logic signed [COORD_BITS-1:0] second_y,
	output logic signed [COORD_BITS+2:0] error_init,
	output logic signed [COORD_BITS+2:0] straight_inc,
	output logic signed [COORD_BITS+2:0] diagonal_inc,
	output logic                         x_major
);

	localparam int E = COORD_BITS + 3;

	logic                        swap;
	logic signed [COORD_BITS:0]  ya_w;
	logic signed [COORD_BITS:0]  yb_w;
	logic signed [COORD_BITS:0]  dy_s;
	logic        [COORD_BITS:0]  dx;
	logic        [COORD_BITS:0]  dy;
	logic        [COORD_BITS:0]  mn;
	logic        [COORD_BITS:0]  mx;
	logic signed [E-1:0]         diff;
	logic signed [E-1:0]         absd;

	always_comb begin
		swap     = start_x > end_x;
		first_x  = swap ? end_x : start_x;
		first_y  = swap ? end_y : start_y;
		second_x = swap ? start_x : end_x;
		second_y = swap ? start_y : end_y;

		dx   = {second_x[COORD_BITS-1], second_x} - {first_x[COORD_BITS-1], first_x};
		ya_w = {first_y[COORD_BITS-1], first_y};
		yb_w = {second_y[COORD_BITS-1], second_y};
		dy_s = yb_w - ya_w;
		dy   = dy_s[COORD_BITS] ? (COORD_BITS+1)'(-dy_s) : dy_s;

		x_major = dx >= dy;
		mn      = x_major ? dy : dx;
		mx      = x_major ? dx : dy;

		straight_inc = $signed({1'b0, mn, 1'b0});
		error_init   = $signed({1'b0, mn, 1'b0}) - $signed({2'b00, mx});
		diff         = $signed({2'b00, dy}) - $signed({2'b00, dx});
		absd         = diff[E-1] ? -diff : diff;
		diagonal_inc = -(absd <<< 1);
	end

endmodule

`default_nettype wire

// ===== hdl/lr_step.sv =====
// One Bresenham step: next position, next error term and end point detection.
// Depends on lr_pkg.
`default_nettype none

module lr_step
	import lr_pkg::*;
#(
	parameter int COORD_BITS = LR_COORD_BITS
) (
	input  logic signed [COORD_BITS-1:0] cur_x,
	input  logic signed [COORD_BITS-1:0] cur_y,
	input  logic signed [COORD_BITS-1:0] target_x,
	input  logic signed [COORD_BITS-1:0] target_y,
	input  logic signed [COORD_BITS+2:0] error_term,
	input  logic signed [COORD_BITS+2:0] straight_inc,
	input  logic signed [COORD_BITS+2:0] diagonal_inc,
	input  logic                         x_major,
	output logic signed [COORD_BITS-1:0] next_x,
	output logic signed [COORD_BITS-1:0] next_y,
	output logic signed [COORD_BITS+2:0] next_error,
	output logic                         is_last
);

	logic moving;
	logic pos;

	always_comb begin
		moving = (cur_x != target_x) || (cur_y != target_y);
		pos    = error_term > 0;
		next_x = cur_x;
		next_y = cur_y;
		next_error = error_term;
		if (moving) begin
			if (pos || x_major) begin
				next_x = cur_x + COORD_BITS'(1);
			end
			if (pos || !x_major) begin
				next_y = (target_y > cur_y) ? cur_y + COORD_BITS'(1) : cur_y - COORD_BITS'(1);
			end
			next_error = error_term + (pos ? diagonal_inc : straight_inc);
		end
		is_last = (next_x == target_x) && (next_y == target_y);
	end

endmodule

`default_nettype wire

// ===== bench/lr_pixel_checker.sv =====
// Pixel checker for the line rasteriser: follows both stream channels, predicts every pixel
// with its own Bresenham walk and compares it with what the block delivers.
// Depends on lr_pkg; instantiated beside the block by tb.
module lr_pixel_checker
	import lr_pkg::*;
#(
	parameter int COORD_BITS = LR_COORD_BITS
) (
	input  logic clk,
	input  logic arst_n,
	input  logic s_axis_tvalid,
	input  logic s_axis_tready,
	input  logic s_axis_tuser,
	input  logic [((4*COORD_BITS+LR_COLOR_BITS+7)/8)*8-1:0] s_axis_tdata,
	input  logic m_axis_tvalid,
	input  logic m_axis_tready,
	input  logic [((2*COORD_BITS+LR_COLOR_BITS+7)/8)*8-1:0] m_axis_tdata,
	input  logic m_axis_tlast,
	output int   errors,
	output int   pending,
	output int   lines_started,
	output int   pixels_seen
);

	typedef struct packed {
		logic signed [COORD_BITS-1:0] x;
		logic signed [COORD_BITS-1:0] y;
		logic [LR_COLOR_BITS-1:0]     colour;
		logic                         last;
	} pixel_t;

	logic signed [COORD_BITS-1:0] pos_x, pos_y, goal_x, goal_y;
	logic signed [COORD_BITS+2:0] err_acc, err_straight, err_diag;
	logic                         along_x;
	logic [LR_COLOR_BITS-1:0]     ink;
	logic                         drawing;
	pixel_t                       pixel_queue[$];

	task automatic report(input string msg);
		errors++;
		if (errors <= 50)
			$display("ERROR: %s", msg);
	endtask

	task automatic load_line(input logic [((4*COORD_BITS+LR_COLOR_BITS+7)/8)*8-1:0] word);
		int xa, ya, xb, yb, swap, dx, dy, lo, hi, skew;
		xa = int'($signed(word[0 +: COORD_BITS]));
		ya = int'($signed(word[COORD_BITS +: COORD_BITS]));
		xb = int'($signed(word[2*COORD_BITS +: COORD_BITS]));
		yb = int'($signed(word[3*COORD_BITS +: COORD_BITS]));
		if (xa > xb) begin
			swap = xa; xa = xb; xb = swap;
			swap = ya; ya = yb; yb = swap;
		end
		dx = xb - xa;
		dy = (yb >= ya) ? yb - ya : ya - yb;
		lo = (dx < dy) ? dx : dy;
		hi = (dx < dy) ? dy : dx;
		skew = (dy >= dx) ? dy - dx : dx - dy;
		pos_x = COORD_BITS'(xa);
		pos_y = COORD_BITS'(ya);
		goal_x = COORD_BITS'(xb);
		goal_y = COORD_BITS'(yb);
		err_acc = (COORD_BITS+3)'(2 * lo - hi);
		err_straight = (COORD_BITS+3)'(2 * lo);
		err_diag = (COORD_BITS+3)'(-2 * skew);
		along_x = (dx >= dy);
		ink = word[4*COORD_BITS +: LR_COLOR_BITS];
		drawing = 1'b1;
		lines_started++;
	endtask

	task automatic advance_pixel();
		pixel_t px;
		logic   climb;
		if (drawing) begin
			if (pos_x != goal_x || pos_y != goal_y) begin
				climb = (err_acc > 0);
				if (climb || along_x)
					pos_x = pos_x + COORD_BITS'(1);
				if (climb || !along_x)
					pos_y = (goal_y > pos_y) ? pos_y + COORD_BITS'(1) : pos_y - COORD_BITS'(1);
				err_acc = err_acc + (climb ? err_diag : err_straight);
			end
			px.x = pos_x;
			px.y = pos_y;
			px.colour = ink;
			px.last = (pos_x == goal_x) && (pos_y == goal_y);
			pixel_queue.push_back(px);
			if (px.last)
				drawing = 1'b0;
		end
	endtask

	task automatic compare_pixel();
		pixel_t seen, want;
		seen.x = m_axis_tdata[0 +: COORD_BITS];
		seen.y = m_axis_tdata[COORD_BITS +: COORD_BITS];
		seen.colour = m_axis_tdata[2*COORD_BITS +: LR_COLOR_BITS];
		seen.last = m_axis_tlast;
		pixels_seen++;
		if (pixel_queue.size() == 0) begin
			report($sformatf("pixel %0d (%0d,%0d) arrived with none expected",
				pixels_seen, seen.x, seen.y));
		end else begin
			want = pixel_queue.pop_front();
			if (seen.x !== want.x)
				report($sformatf("pixel %0d: x is %0d, expected %0d", pixels_seen, seen.x, want.x));
			if (seen.y !== want.y)
				report($sformatf("pixel %0d: y is %0d, expected %0d", pixels_seen, seen.y, want.y));
			if (seen.colour !== want.colour)
				report($sformatf("pixel %0d: colour is %06h, expected %06h",
					pixels_seen, seen.colour, want.colour));
			if (seen.last !== want.last)
				report($sformatf("pixel %0d: last is %b, expected %b",
					pixels_seen, seen.last, want.last));
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_x = '0;
			pos_y = '0;
			goal_x = '0;
			goal_y = '0;
			err_acc = '0;
			err_straight = '0;
			err_diag = '0;
			along_x = 1'b0;
			ink = '0;
			drawing = 1'b0;
			pixel_queue.delete();
			errors = 0;
			pending = 0;
			lines_started = 0;
			pixels_seen = 0;
		end else begin
			// Outputs are compared first: a pixel leaving now stems from an earlier item.
			if (m_axis_tvalid && m_axis_tready)
				compare_pixel();
			if (s_axis_tvalid && s_axis_tready) begin
				if (s_axis_tuser == LR_OP_START)
					load_line(s_axis_tdata);
				else
					advance_pixel();
			end
			pending = pixel_queue.size();
		end
	end

endmodule

// ===== bench/tb.sv =====
// Testbench top for the line rasteriser: clock, reset, line stimulus and the verdict.
// Depends on lr_pkg, line_rasterizer_top and lr_pixel_checker.
module tb;
	import lr_pkg::*;

	localparam int CB = LR_COORD_BITS;
	localparam int IN_W = ((4*CB+LR_COLOR_BITS+7)/8)*8;
	localparam int OUT_W = ((2*CB+LR_COLOR_BITS+7)/8)*8;
	localparam int QUIET_LIMIT = 5000;
	localparam int HOLD_CYCLES = 400;

	logic             clk = 1'b0;
	logic             arst_n = 1'b0;
	logic             s_axis_tvalid = 1'b0;
	logic             s_axis_tready;
	logic             s_axis_tuser = LR_OP_STEP;
	logic [IN_W-1:0]  s_axis_tdata = '0;
	logic             m_axis_tvalid;
	logic             m_axis_tready = 1'b0;
	logic [OUT_W-1:0] m_axis_tdata;
	logic             m_axis_tlast;

	int   errors, pending, lines_started, pixels_seen;
	int   send_idle_pct = 24;
	int   recv_idle_pct = 51;
	int   items_sent = 0;
	int   quiet_cycles = 0;
	logic hold_req = 1'b0;
	logic hold_done = 1'b0;

	always #1 clk = ~clk;

	line_rasterizer_top #(.COORD_BITS(CB)) uut (
		.clk(clk),
		.arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tuser(s_axis_tuser),
		.s_axis_tdata(s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.m_axis_tlast(m_axis_tlast)
	);

	lr_pixel_checker #(.COORD_BITS(CB)) pixel_check (
		.clk(clk),
		.arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tuser(s_axis_tuser),
		.s_axis_tdata(s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.m_axis_tlast(m_axis_tlast),
		.errors(errors),
		.pending(pending),
		.lines_started(lines_started),
		.pixels_seen(pixels_seen)
	);

	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("Timeout: no item moved for %0d cycles", QUIET_LIMIT);
				$display("Testbench completed WITH ERRORS");
				$finish;
			end
		end
	end

	// The long hold-off is counted here so that the sender keeps offering items meanwhile.
	initial begin
		forever begin
			@(posedge clk);
			if (hold_req && !hold_done) begin
				m_axis_tready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_done = 1'b1;
			end else begin
				m_axis_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
			end
		end
	end

	function automatic int rand_coord();
		return int'($urandom_range(0, 65535)) - 32768;
	endfunction

	function automatic int clamp_coord(input int v);
		if (v > 32767)
			return 32767;
		if (v < -32768)
			return -32768;
		return v;
	endfunction

	function automatic int line_steps(input int sx, input int sy, input int ex, input int ey);
		int dx, dy;
		dx = (ex >= sx) ? ex - sx : sx - ex;
		dy = (ey >= sy) ? ey - sy : sy - ey;
		if (dx == 0 && dy == 0)
			return 1;
		return (dx > dy) ? dx : dy;
	endfunction

	task automatic send_item(input logic op, input int sx, input int sy, input int ex,
			input int ey, input logic [LR_COLOR_BITS-1:0] colour);
		logic [IN_W-1:0] word;
		word = '0;
		word[0 +: CB] = sx[CB-1:0];
		word[CB +: CB] = sy[CB-1:0];
		word[2*CB +: CB] = ex[CB-1:0];
		word[3*CB +: CB] = ey[CB-1:0];
		word[4*CB +: LR_COLOR_BITS] = colour;
		if ($urandom_range(0, 99) < send_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			do
				@(posedge clk);
			while ($urandom_range(0, 99) < send_idle_pct);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tuser <= op;
		s_axis_tdata <= word;
		do
			@(posedge clk);
		while (!s_axis_tready);
		items_sent++;
	endtask

	// Step items carry random payloads, which the block must ignore.
	task automatic send_steps(input int count);
		repeat (count)
			send_item(LR_OP_STEP, rand_coord(), rand_coord(), rand_coord(), rand_coord(),
				LR_COLOR_BITS'($urandom));
	endtask

	task automatic draw_line(input int sx, input int sy, input int ex, input int ey,
			input logic [LR_COLOR_BITS-1:0] colour, input int steps);
		send_item(LR_OP_START, sx, sy, ex, ey, colour);
		send_steps(steps);
	endtask

	task automatic random_line();
		int sx, sy, ex, ey, span, d, full, mode;
		sx = rand_coord();
		sy = rand_coord();
		if ($urandom_range(0, 9) == 0)
			sx = $urandom_range(0, 1) ? 32767 - int'($urandom_range(0, 3))
				: -32768 + int'($urandom_range(0, 3));
		if ($urandom_range(0, 9) == 0)
			sy = $urandom_range(0, 1) ? 32767 - int'($urandom_range(0, 3))
				: -32768 + int'($urandom_range(0, 3));
		span = ($urandom_range(0, 19) == 0) ? $urandom_range(13, 300) : $urandom_range(0, 12);
		d = int'($urandom_range(0, 2 * span)) - span;
		case ($urandom_range(0, 9))
			0: begin
				ex = sx;
				ey = sy;
			end
			1: begin
				ex = sx + d;
				ey = sy;
			end
			2: begin
				ex = sx;
				ey = sy + d;
			end
			3: begin
				ex = sx + d;
				ey = $urandom_range(0, 1) ? sy + d : sy - d;
			end
			default: begin
				ex = sx + d;
				ey = sy + int'($urandom_range(0, 2 * span)) - span;
			end
		endcase
		ex = clamp_coord(ex);
		ey = clamp_coord(ey);
		full = line_steps(sx, sy, ex, ey);
		mode = $urandom_range(0, 99);
		if (mode < 85)
			draw_line(sx, sy, ex, ey, LR_COLOR_BITS'($urandom), full);
		else if (mode < 93)
			draw_line(sx, sy, ex, ey, LR_COLOR_BITS'($urandom), $urandom_range(0, full - 1));
		else
			draw_line(sx, sy, ex, ey, LR_COLOR_BITS'($urandom),
				full + int'($urandom_range(1, 3)));
	endtask

	initial begin
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_steps(1);
		draw_line(-32768, -32768, 32767, 32767, 24'hFFFFFF, 3);
		draw_line(32767, -32768, -32768, 32767, 24'h000000, 2);
		draw_line(0, 32767, 5, -32768, 24'h5A5A5A, 2);
		draw_line(32767, -32768, 32767, -32768, 24'hA5A5A5, 1);
		send_steps(1);
		draw_line(32765, 32767, 32760, 32764, 24'h123456, 5);
		draw_line(-32768, -32768, -32766, -32768, 24'hEDCBA9, 2);
		draw_line(-3, 5, -3, -1, 24'h800001, 6);
		while (items_sent < 360)
			random_line();

		send_idle_pct = 51;
		recv_idle_pct = 24;
		while (items_sent < 690)
			random_line();

		send_idle_pct = 0;
		recv_idle_pct = 0;
		hold_req = 1'b1;
		draw_line(-32768, -20000, -32618, -19900, LR_COLOR_BITS'($urandom), 150);
		while (items_sent < 1000)
			random_line();

		s_axis_tvalid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);

		$display("Run covered %0d line starts and %0d checked pixels, with steps while idle,",
			lines_started, pixels_seen);
		$display("abandoned and zero-length lines, extreme endpoints and a long line sent into a held output.");
		if (errors == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule

// ===== files.f =====
hdl/lr_pkg.sv
hdl/lr_setup.sv
hdl/lr_step.sv
hdl/line_rasterizer_top.sv
bench/lr_pixel_checker.sv
bench/tb.sv
